/* rtl/core/mae_pkg.sv */
package mae_pkg;

	typedef enum logic [4:0] {
		ACT_ADD   = 5'd0,
		ACT_ADDI  = 5'd1,
		ACT_ADDIU = 5'd2,
		ACT_ADDU  = 5'd3,
		ACT_SUB   = 5'd4,
		ACT_SUBU  = 5'd5,
		ACT_DIV   = 5'd6,
		ACT_DIVU  = 5'd7,
		ACT_MULT  = 5'd8,
		ACT_MULTU = 5'd9,
		ACT_SLL   = 5'd10,
		ACT_SLLV  = 5'd11,
		ACT_SRA   = 5'd12,
		ACT_SRAV  = 5'd13,
		ACT_SRL   = 5'd14,
		ACT_SRLV  = 5'd15,
		ACT_AND   = 5'd16,
		ACT_ANDI  = 5'd17,
		ACT_NOR   = 5'd18,
		ACT_OR    = 5'd19,
		ACT_ORI   = 5'd20,
		ACT_XOR   = 5'd21,
		ACT_XORI  = 5'd22,
		ACT_SLT   = 5'd23,
		ACT_SLTI  = 5'd24,
		ACT_SLTIU = 5'd25,
		ACT_SLTU  = 5'd26,
		ACT_WRREG = 5'd27,
		ACT_RDREG = 5'd28
	} action_t;

	// operation class chosen by the front end
	typedef enum logic [1:0] {
		CLS_SIMPLE = 2'd0,
		CLS_MUL    = 2'd1,
		CLS_DIV    = 2'd2,
		CLS_NONE   = 2'd3
	} op_class_t;

	typedef struct packed {
		logic [4:0]  action;
		op_class_t   cls;
		logic        is_signed;
		logic [4:0]  src_index;
		logic [4:0]  tgt_index;
		logic [4:0]  dst_index;
		logic [4:0]  shift_amount;
		logic [15:0] immediate;
		logic [31:0] load_value;
	} issue_t;

	typedef struct packed {
		logic        dest_written;
		logic [4:0]  dest_number;
		logic [31:0] dest_value;
		logic [31:0] hi_value;
		logic [31:0] lo_value;
		logic        overflow_trap;
	} result_t;

	localparam int QUEUE_DEPTH = 2;

endpackage

/* rtl/core/mae_if.sv */
interface mae_in_if;
	logic        valid;
	logic        ready;
	logic [4:0]  action;
	logic [4:0]  src_index;
	logic [4:0]  tgt_index;
	logic [4:0]  dst_index;
	logic [4:0]  shift_amount;
	logic [15:0] immediate;
	logic [31:0] load_value;
	modport source (output valid, action, src_index, tgt_index, dst_index, shift_amount,
		immediate, load_value, input ready);
	modport sink (input valid, action, src_index, tgt_index, dst_index, shift_amount,
		immediate, load_value, output ready);
endinterface

interface mae_out_if;
	logic        valid;
	logic        ready;
	logic        dest_written;
	logic [4:0]  dest_number;
	logic [31:0] dest_value;
	logic [31:0] hi_value;
	logic [31:0] lo_value;
	logic        overflow_trap;
	modport source (output valid, dest_written, dest_number, dest_value, hi_value,
		lo_value, overflow_trap, input ready);
	modport sink (input valid, dest_written, dest_number, dest_value, hi_value,
		lo_value, overflow_trap, output ready);
endinterface

/* rtl/core/mips_alu_execute_top.sv */
// MIPS I integer execute block with a 32-entry register file plus HI/LO.
// Items enter a two-entry queue after classification; the back end runs
// them one at a time. Simple ALU ops, preload and readback use issue and
// the result register; multiply adds two 16x32 partial-product steps;
// divide adds BK_DIV, one restoring-division bit per cycle, and
// BK_DIVFIX, skipped for divide by zero and the MIN / -1 case. The
// result waits in the output register; the queue accepts until full.
module mips_alu_execute_top #(
	parameter int REG_COUNT = 32
) (
	input logic       clk,
	input logic       arst_n,
	mae_in_if.sink    in_ch,
	mae_out_if.source out_ch
);
	mae_pkg::issue_t q_data;
	logic            q_valid, q_pop;

	// fixed 32-entry file
	if (REG_COUNT != 32) begin : g_bad
		$error("REG_COUNT must be 32");
	end

	// accept and classify
	mae_front u_front (.clk, .arst_n, .in_ch, .q_data, .q_valid, .q_pop);
	// execute and hold the result
	mae_back u_back (.clk, .arst_n, .q_data, .q_valid, .q_pop, .out_ch);
endmodule

/* rtl/core/mae_front.sv */
module mae_front (
	input  logic            clk,
	input  logic            arst_n,
	mae_in_if.sink          in_ch,
	output mae_pkg::issue_t q_data,
	output logic            q_valid,
	input  logic            q_pop
);
	localparam int AW = $clog2(mae_pkg::QUEUE_DEPTH);

	mae_pkg::issue_t      mem_q [mae_pkg::QUEUE_DEPTH];
	logic [AW-1:0]        wp_q, rp_q;
	logic [AW:0]          cnt_q;
	mae_pkg::issue_t      cls_item;
	logic                 push;

	always_comb begin
		cls_item.action       = in_ch.action;
		cls_item.src_index    = in_ch.src_index;
		cls_item.tgt_index    = in_ch.tgt_index;
		cls_item.dst_index    = in_ch.dst_index;
		cls_item.shift_amount = in_ch.shift_amount;
		cls_item.immediate    = in_ch.immediate;
		cls_item.load_value   = in_ch.load_value;
		cls_item.is_signed    = (in_ch.action == mae_pkg::ACT_DIV) ||
			(in_ch.action == mae_pkg::ACT_MULT);
		unique case (in_ch.action) inside
			mae_pkg::ACT_MULT, mae_pkg::ACT_MULTU: cls_item.cls = mae_pkg::CLS_MUL;
			mae_pkg::ACT_DIV, mae_pkg::ACT_DIVU:   cls_item.cls = mae_pkg::CLS_DIV;
			[5'd29:5'd31]:                         cls_item.cls = mae_pkg::CLS_NONE;
			default:                               cls_item.cls = mae_pkg::CLS_SIMPLE;
		endcase
	end

	assign in_ch.ready = (cnt_q != (AW+1)'(mae_pkg::QUEUE_DEPTH));
	assign push        = in_ch.valid && in_ch.ready;
	assign q_valid     = (cnt_q != '0);
	assign q_data      = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= cls_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (q_pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(q_pop);
		end
	end
endmodule

/* rtl/core/mae_back.sv */
module mae_back (
	input  logic            clk,
	input  logic            arst_n,
	input  mae_pkg::issue_t q_data,
	input  logic            q_valid,
	output logic            q_pop,
	mae_out_if.source       out_ch
);
	typedef enum logic [2:0] {
		BK_IDLE, BK_MUL1, BK_MUL2, BK_DIV, BK_DIVFIX, BK_OUT
	} bk_state_t;

	bk_state_t       st_q, st_d;
	logic [31:0]     rf_q [1:31];
	logic [31:0]     hi_q, lo_q;
	logic [31:0]     a, b, imms, immz, val;
	logic            wr, trap;
	logic [4:0]      dnum;
	logic [31:0]     t_add, t_addi, t_sub;
	logic [4:0]      sh;
	mae_pkg::result_t res_q;
	mae_pkg::issue_t  it_q;
	// multiply: two 16x32 partial products summed in BK_MUL1 and BK_MUL2
	logic [31:0]     ma_q, mb_q;
	logic [63:0]     acc_q;
	logic            neg_q, rneg_q;
	logic [5:0]      cnt_q;
	logic [31:0]     rem_q, quo_q;
	logic [32:0]     trial;
	logic [47:0]     pp;
	logic            div_special;

	function automatic logic [31:0] rdreg(input logic [4:0] i, input logic [31:0] v);
		return (i == 5'd0) ? 32'd0 : v;
	endfunction

	assign a    = rdreg(q_data.src_index, rf_q[q_data.src_index == 0 ? 5'd1 : q_data.src_index]);
	assign b    = rdreg(q_data.tgt_index, rf_q[q_data.tgt_index == 0 ? 5'd1 : q_data.tgt_index]);
	assign imms = {{16{q_data.immediate[15]}}, q_data.immediate};
	assign immz = {16'd0, q_data.immediate};
	assign t_add  = a + b;
	assign t_addi = a + imms;
	assign t_sub  = a - b;
	assign sh     = a[4:0];
	assign div_special = q_data.is_signed && a == 32'h8000_0000 && b == 32'hFFFF_FFFF;

	always_comb begin
		wr = 1'b1; trap = 1'b0; dnum = q_data.dst_index; val = '0;
		case (q_data.action)
			mae_pkg::ACT_ADD: begin
				val = t_add;
				if (((a ^ t_add) & (b ^ t_add)) >> 31 != 0) begin trap = 1'b1; wr = 1'b0; end
			end
			mae_pkg::ACT_ADDI: begin
				dnum = q_data.tgt_index; val = t_addi;
				if (((a ^ t_addi) & (imms ^ t_addi)) >> 31 != 0) begin
					trap = 1'b1; wr = 1'b0;
				end
			end
			mae_pkg::ACT_ADDIU: begin dnum = q_data.tgt_index; val = t_addi; end
			mae_pkg::ACT_ADDU:  val = t_add;
			mae_pkg::ACT_SUB: begin
				val = t_sub;
				if (((a ^ b) & (a ^ t_sub)) >> 31 != 0) begin trap = 1'b1; wr = 1'b0; end
			end
			mae_pkg::ACT_SUBU:  val = t_sub;
			mae_pkg::ACT_SLL:   val = b << q_data.shift_amount;
			mae_pkg::ACT_SLLV:  val = b << sh;
			mae_pkg::ACT_SRA:   val = 32'($signed(b) >>> q_data.shift_amount);
			mae_pkg::ACT_SRAV:  val = 32'($signed(b) >>> sh);
			mae_pkg::ACT_SRL:   val = b >> q_data.shift_amount;
			mae_pkg::ACT_SRLV:  val = b >> sh;
			mae_pkg::ACT_AND:   val = a & b;
			mae_pkg::ACT_ANDI: begin dnum = q_data.tgt_index; val = a & immz; end
			mae_pkg::ACT_NOR:   val = ~(a | b);
			mae_pkg::ACT_OR:    val = a | b;
			mae_pkg::ACT_ORI:  begin dnum = q_data.tgt_index; val = a | immz; end
			mae_pkg::ACT_XOR:   val = a ^ b;
			mae_pkg::ACT_XORI: begin dnum = q_data.tgt_index; val = a ^ immz; end
			mae_pkg::ACT_SLT:   val = {31'd0, $signed(a) < $signed(b)};
			mae_pkg::ACT_SLTI: begin
				dnum = q_data.tgt_index; val = {31'd0, $signed(a) < $signed(imms)};
			end
			mae_pkg::ACT_SLTIU: begin dnum = q_data.tgt_index; val = {31'd0, a < imms}; end
			mae_pkg::ACT_SLTU:  val = {31'd0, a < b};
			mae_pkg::ACT_WRREG: val = q_data.load_value;
			mae_pkg::ACT_RDREG: begin
				wr = 1'b0;
				val = rdreg(q_data.dst_index,
					rf_q[q_data.dst_index == 0 ? 5'd1 : q_data.dst_index]);
			end
			default: wr = 1'b0;
		endcase
		if (wr && dnum == 5'd0) wr = 1'b0;
		if (!wr && q_data.action != mae_pkg::ACT_RDREG) begin dnum = '0; val = '0; end
	end

	assign trial = {rem_q[31:0], quo_q[31]} - {1'b0, mb_q};
	assign pp    = mb_q * ma_q[15:0];

	assign out_ch.valid         = (st_q == BK_OUT);
	assign out_ch.dest_written  = res_q.dest_written;
	assign out_ch.dest_number   = res_q.dest_number;
	assign out_ch.dest_value    = res_q.dest_value;
	assign out_ch.hi_value      = res_q.hi_value;
	assign out_ch.lo_value      = res_q.lo_value;
	assign out_ch.overflow_trap = res_q.overflow_trap;

	always_comb begin
		st_d  = st_q;
		q_pop = 1'b0;
		unique case (st_q)
			BK_IDLE: if (q_valid) begin
				q_pop = 1'b1;
				unique case (q_data.cls)
					mae_pkg::CLS_MUL: st_d = BK_MUL1;
					mae_pkg::CLS_DIV: st_d = (b == 0 || div_special) ? BK_OUT : BK_DIV;
					default:          st_d = BK_OUT;
				endcase
			end
			BK_MUL1:   st_d = BK_MUL2;
			BK_MUL2:   st_d = BK_OUT;
			BK_DIV:    if (cnt_q == 6'd31) st_d = BK_DIVFIX;
			BK_DIVFIX: st_d = BK_OUT;
			BK_OUT:    if (out_ch.ready) st_d = BK_IDLE;
			default:   st_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE;
			hi_q <= '0;
			lo_q <= '0;
			for (int i = 1; i < 32; i++) rf_q[i] <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == BK_IDLE && q_valid) begin
				it_q <= q_data;
				res_q.dest_written  <= wr;
				res_q.dest_number   <= dnum;
				res_q.dest_value    <= val;
				res_q.overflow_trap <= trap;
				if (wr && q_data.cls == mae_pkg::CLS_SIMPLE) rf_q[dnum] <= val;
				// operand magnitudes for the iterative units
				neg_q  <= q_data.is_signed && (a[31] ^ b[31]);
				rneg_q <= q_data.is_signed && a[31];
				ma_q   <= (q_data.is_signed && a[31]) ? 32'(-a) : a;
				mb_q   <= (q_data.is_signed && b[31]) ? 32'(-b) : b;
				quo_q  <= (q_data.is_signed && a[31]) ? 32'(-a) : a;
				rem_q  <= '0;
				cnt_q  <= '0;
				acc_q  <= '0;
				if (q_data.cls == mae_pkg::CLS_DIV && div_special) begin
					hi_q <= '0; lo_q <= 32'h8000_0000;
					res_q.hi_value <= '0; res_q.lo_value <= 32'h8000_0000;
				end else begin
					res_q.hi_value <= hi_q;
					res_q.lo_value <= lo_q;
				end
			end
			if (st_q == BK_MUL1) begin
				acc_q <= {16'd0, pp};
				ma_q  <= {16'd0, ma_q[31:16]};
			end
			if (st_q == BK_MUL2) begin : mul_done
				logic [63:0] p;
				logic [4:0]  d;
				p = acc_q + {pp, 16'd0};
				if (neg_q) p = -p;
				d = it_q.dst_index;
				hi_q <= p[63:32];
				lo_q <= p[31:0];
				res_q.hi_value <= p[63:32];
				res_q.lo_value <= p[31:0];
				if (d != 5'd0) begin
					rf_q[d] <= p[31:0];
					res_q.dest_written <= 1'b1;
					res_q.dest_number  <= d;
					res_q.dest_value   <= p[31:0];
				end
			end
			if (st_q == BK_DIV) begin
				cnt_q <= cnt_q + 6'd1;
				if (!trial[32]) begin
					rem_q <= trial[31:0];
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= {rem_q[30:0], quo_q[31]};
					quo_q <= {quo_q[30:0], 1'b0};
				end
			end
			if (st_q == BK_DIVFIX) begin
				hi_q <= rneg_q ? 32'(-rem_q) : rem_q;
				lo_q <= neg_q ? 32'(-quo_q) : quo_q;
				res_q.hi_value <= rneg_q ? 32'(-rem_q) : rem_q;
				res_q.lo_value <= neg_q ? 32'(-quo_q) : quo_q;
			end
		end
	end
endmodule
